/* rtl/rm2q_pkg.sv */
`default_nettype none

package rm2q_pkg;

  // number format
  localparam int FracBits = 14;
  localparam int DataW    = 16;
  localparam int NumW     = DataW + 1;
  localparam int One      = 1 << FracBits;

  // radicand, root and divider widths
  localparam int RadW     = ((FracBits > DataW + 1) ? FracBits : DataW + 1) + 2;
  localparam int SqInRawW = RadW - 1 + FracBits;
  localparam int SqInW    = SqInRawW + (SqInRawW % 2);
  localparam int SqrtW    = SqInW / 2;
  localparam int RemW     = SqrtW + 2;
  localparam int DvdW     = ((NumW + FracBits > SqrtW) ? NumW + FracBits : SqrtW) + 1;
  localparam int DsrW     = SqrtW + 1;
  localparam int DRemW    = DsrW + 1;

  // saturation limits, as magnitudes
  localparam int SatHi    = (One < 32767) ? One : 32767;
  localparam int SatLo    = (One < 32768) ? One : 32768;

  // off-diagonal lanes and queue depth
  localparam int Lanes    = 3;
  localparam int QDepth   = 2;
  localparam int QPtrW    = $clog2(QDepth);
  localparam int QCntW    = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    BrTrace = 2'd0,
    BrX     = 2'd1,
    BrY     = 2'd2,
    BrZ     = 2'd3
  } branch_e;

  // classified matrix, front to back
  typedef struct packed {
    logic signed [RadW-1:0]       rad;
    logic [Lanes-1:0][NumW-1:0]   n;
    branch_e                      br;
    logic                         degen;
  } cls_t;

  // data that rides along the divider
  typedef struct packed {
    branch_e            br;
    logic               degen;
    logic [SqrtW-1:0]   half;
    logic [Lanes-1:0]   neg;
  } side_t;

endpackage

`default_nettype wire

/* rtl/rm2q_if.sv */
`default_nettype none

interface rm2q_mat_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [rm2q_pkg::DataW-1:0]      m00;
  logic signed [rm2q_pkg::DataW-1:0]      m01;
  logic signed [rm2q_pkg::DataW-1:0]      m02;
  logic signed [rm2q_pkg::DataW-1:0]      m10;
  logic signed [rm2q_pkg::DataW-1:0]      m11;
  logic signed [rm2q_pkg::DataW-1:0]      m12;
  logic signed [rm2q_pkg::DataW-1:0]      m20;
  logic signed [rm2q_pkg::DataW-1:0]      m21;
  logic signed [rm2q_pkg::DataW-1:0]      m22;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
  modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  output ready);
endinterface

interface rm2q_quat_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [rm2q_pkg::DataW-1:0]      qa;
  logic signed [rm2q_pkg::DataW-1:0]      qb;
  logic signed [rm2q_pkg::DataW-1:0]      qc;
  logic signed [rm2q_pkg::DataW-1:0]      qw;
  logic [1:0]                             branch_used;
  logic                                   degenerate;

  modport source (output valid, qa, qb, qc, qw, branch_used, degenerate,
                  input ready);
  modport sink   (input valid, qa, qb, qc, qw, branch_used, degenerate,
                  output ready);
endinterface

`default_nettype wire

/* rtl/rm2q_front.sv */
`default_nettype none

module rm2q_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  rm2q_mat_if.sink           mat_i,
  output rm2q_pkg::cls_t     cls_o,
  output logic               valid_o,
  input  wire logic          ready_i
);

  logic signed [rm2q_pkg::RadW-1:0] e00, e11, e22, one_c, trace;
  logic signed [rm2q_pkg::NumW-1:0] a01, d01, a02, d02, a12, d12;
  rm2q_pkg::cls_t                   cls_d, cls_q;
  logic                             v_q;

  // sign-extended diagonal and off-diagonal sums
  assign e00   = rm2q_pkg::RadW'(mat_i.m00);
  assign e11   = rm2q_pkg::RadW'(mat_i.m11);
  assign e22   = rm2q_pkg::RadW'(mat_i.m22);
  assign one_c = rm2q_pkg::RadW'(rm2q_pkg::One);
  assign trace = e00 + e11 + e22;

  assign a01 = rm2q_pkg::NumW'(mat_i.m01) + rm2q_pkg::NumW'(mat_i.m10);
  assign d01 = rm2q_pkg::NumW'(mat_i.m01) - rm2q_pkg::NumW'(mat_i.m10);
  assign a02 = rm2q_pkg::NumW'(mat_i.m20) + rm2q_pkg::NumW'(mat_i.m02);
  assign d02 = rm2q_pkg::NumW'(mat_i.m20) - rm2q_pkg::NumW'(mat_i.m02);
  assign a12 = rm2q_pkg::NumW'(mat_i.m12) + rm2q_pkg::NumW'(mat_i.m21);
  assign d12 = rm2q_pkg::NumW'(mat_i.m12) - rm2q_pkg::NumW'(mat_i.m21);

  // branch choice, radicand and numerators
  always_comb begin
    if (trace > 0) begin
      cls_d.br   = rm2q_pkg::BrTrace;
      cls_d.rad  = one_c + trace;
      cls_d.n[0] = d12;
      cls_d.n[1] = d02;
      cls_d.n[2] = d01;
    end else if (mat_i.m00 > mat_i.m11 && mat_i.m00 > mat_i.m22) begin
      cls_d.br   = rm2q_pkg::BrX;
      cls_d.rad  = one_c + e00 - e11 - e22;
      cls_d.n[0] = a01;
      cls_d.n[1] = a02;
      cls_d.n[2] = d12;
    end else if (mat_i.m11 > mat_i.m22) begin
      cls_d.br   = rm2q_pkg::BrY;
      cls_d.rad  = one_c + e11 - e22 - e00;
      cls_d.n[0] = a01;
      cls_d.n[1] = a12;
      cls_d.n[2] = d02;
    end else begin
      cls_d.br   = rm2q_pkg::BrZ;
      cls_d.rad  = one_c + e22 - e00 - e11;
      cls_d.n[0] = a02;
      cls_d.n[1] = a12;
      cls_d.n[2] = d01;
    end
    cls_d.degen = (cls_d.rad <= 0);
  end

  // one register stage toward the queue
  assign mat_i.ready = !v_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (mat_i.ready) begin
      v_q <= mat_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mat_i.ready) begin
      cls_q <= cls_d;
    end
  end

  assign cls_o   = cls_q;
  assign valid_o = v_q;

endmodule

`default_nettype wire

/* rtl/rm2q_queue.sv */
`default_nettype none

module rm2q_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  rm2q_pkg::cls_t        cls_i,
  input  wire logic             valid_i,
  output logic                  ready_o,
  output rm2q_pkg::cls_t        cls_o,
  output logic                  valid_o,
  input  wire logic             ready_i
);

  rm2q_pkg::cls_t                 mem [rm2q_pkg::QDepth];
  logic [rm2q_pkg::QPtrW-1:0]     wr_q, rd_q;
  logic [rm2q_pkg::QCntW-1:0]     cnt_q;
  logic                           push, pop;

  assign ready_o = (cnt_q != rm2q_pkg::QCntW'(rm2q_pkg::QDepth));
  assign valid_o = (cnt_q != '0);
  assign push    = valid_i && ready_o;
  assign pop     = valid_o && ready_i;
  assign cls_o   = mem[rd_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem[wr_q] <= cls_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/rm2q_div.sv */
`default_nettype none

module rm2q_div (
  input  wire logic                                           clk_i,
  input  wire logic                                           rst_ni,
  input  wire logic                                           en_i,
  input  wire logic                                           valid_i,
  input  wire logic [rm2q_pkg::Lanes-1:0][rm2q_pkg::DvdW-1:0] dvd_i,
  input  wire logic [rm2q_pkg::DsrW-1:0]                      dsr_i,
  input  rm2q_pkg::side_t                                     side_i,
  output logic                                                valid_o,
  output logic [rm2q_pkg::Lanes-1:0][rm2q_pkg::DvdW-1:0]      quo_o,
  output rm2q_pkg::side_t                                     side_o
);

  localparam int Stages = rm2q_pkg::DvdW;

  typedef struct packed {
    logic [rm2q_pkg::Lanes-1:0][rm2q_pkg::DvdW-1:0]  dq;
    logic [rm2q_pkg::Lanes-1:0][rm2q_pkg::DRemW-1:0] rem;
    logic [rm2q_pkg::DsrW-1:0]                       dsr;
    rm2q_pkg::side_t                                 side;
  } dv_t;

  // one quotient bit per lane
  function automatic dv_t dv_step(dv_t p);
    dv_t                       r;
    logic [rm2q_pkg::DRemW-1:0] rem2;
    logic                      qb;
    r = p;
    for (int j = 0; j < rm2q_pkg::Lanes; j++) begin
      rem2 = {p.rem[j][rm2q_pkg::DRemW-2:0], p.dq[j][rm2q_pkg::DvdW-1]};
      qb   = (rem2 >= rm2q_pkg::DRemW'(p.dsr));
      r.rem[j] = qb ? (rem2 - rm2q_pkg::DRemW'(p.dsr)) : rem2;
      r.dq[j]  = {p.dq[j][rm2q_pkg::DvdW-2:0], qb};
    end
    return r;
  endfunction

  dv_t               dv_in;
  dv_t               dv_d [Stages];
  dv_t               dv_q [Stages];
  logic [Stages-1:0] v_q;

  always_comb begin
    dv_in.dq   = dvd_i;
    dv_in.rem  = '0;
    dv_in.dsr  = dsr_i;
    dv_in.side = side_i;
  end

  // restoring division stages
  for (genvar k = 0; k < Stages; k++) begin : g_stage
    if (k == 0) begin : g_first
      always_comb dv_d[k] = dv_step(dv_in);
    end else begin : g_next
      always_comb dv_d[k] = dv_step(dv_q[k-1]);
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_q[k] <= dv_d[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[Stages-2:0], valid_i};
    end
  end

  assign valid_o = v_q[Stages-1];
  assign quo_o   = dv_q[Stages-1].dq;
  assign side_o  = dv_q[Stages-1].side;

endmodule

`default_nettype wire

/* rtl/rm2q_back.sv */
`default_nettype none

module rm2q_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  rm2q_pkg::cls_t     cls_i,
  input  wire logic          valid_i,
  output logic               ready_o,
  rm2q_quat_if.source        quat_o
);

  localparam int Steps = rm2q_pkg::SqrtW;

  typedef struct packed {
    logic [rm2q_pkg::SqInW-1:0]                      rest;
    logic [rm2q_pkg::RemW-1:0]                       rem;
    logic [rm2q_pkg::SqrtW-1:0]                      root;
    logic [rm2q_pkg::Lanes-1:0][rm2q_pkg::NumW-1:0]  n;
    rm2q_pkg::branch_e                               br;
    logic                                            degen;
  } sq_t;

  // one root bit from the next two radicand bits
  function automatic sq_t sq_step(sq_t p);
    sq_t                       r;
    logic [rm2q_pkg::RemW-1:0] rem2;
    logic [rm2q_pkg::RemW-1:0] trial;
    r     = p;
    rem2  = {p.rem[rm2q_pkg::RemW-3:0], p.rest[rm2q_pkg::SqInW-1 -: 2]};
    trial = {p.root, 2'b01};
    r.rest = {p.rest[rm2q_pkg::SqInW-3:0], 2'b00};
    if (rem2 >= trial) begin
      r.rem  = rem2 - trial;
      r.root = {p.root[rm2q_pkg::SqrtW-2:0], 1'b1};
    end else begin
      r.rem  = rem2;
      r.root = {p.root[rm2q_pkg::SqrtW-2:0], 1'b0};
    end
    return r;
  endfunction

  // clamp a magnitude and apply its sign
  function automatic logic [rm2q_pkg::DataW-1:0] sat_part(
    logic [rm2q_pkg::DvdW-1:0] mag, logic neg);
    logic [rm2q_pkg::DvdW-1:0] lim;
    logic [rm2q_pkg::NumW-1:0] m;
    lim = neg ? rm2q_pkg::DvdW'(rm2q_pkg::SatLo) : rm2q_pkg::DvdW'(rm2q_pkg::SatHi);
    m   = (mag > lim) ? rm2q_pkg::NumW'(lim) : rm2q_pkg::NumW'(mag);
    m   = neg ? (~m + 1'b1) : m;
    return m[rm2q_pkg::DataW-1:0];
  endfunction

  logic                                            en;
  sq_t                                             sq_in;
  sq_t                                             sq_d [Steps];
  sq_t                                             sq_q [Steps];
  logic [Steps-1:0]                                sq_v_q;
  logic [rm2q_pkg::SqrtW-1:0]                      root;
  logic [rm2q_pkg::Lanes-1:0][rm2q_pkg::DvdW-1:0]  dvd;
  logic [rm2q_pkg::Lanes-1:0][rm2q_pkg::NumW-1:0]  mag;
  logic [rm2q_pkg::SqrtW:0]                        half_w;
  rm2q_pkg::side_t                                 side_in, side_out;
  logic                                            dv_valid;
  logic [rm2q_pkg::Lanes-1:0][rm2q_pkg::DvdW-1:0]  quo;
  logic [rm2q_pkg::DataW-1:0]                      p0, p1, p2, ph;
  logic [rm2q_pkg::DataW-1:0]                      qa_d, qb_d, qc_d, qw_d;
  logic [rm2q_pkg::DataW-1:0]                      qa_q, qb_q, qc_q, qw_q;
  rm2q_pkg::branch_e                               br_q;
  logic                                            dg_q, out_v_q;

  // whole back end moves when the output register frees up
  assign en      = !out_v_q || quat_o.ready;
  assign ready_o = en;

  always_comb begin
    sq_in.rest  = cls_i.degen ? '0 :
                  rm2q_pkg::SqInW'({cls_i.rad[rm2q_pkg::RadW-2:0],
                                    {rm2q_pkg::FracBits{1'b0}}});
    sq_in.rem   = '0;
    sq_in.root  = '0;
    sq_in.n     = cls_i.n;
    sq_in.br    = cls_i.br;
    sq_in.degen = cls_i.degen;
  end

  // square root stages
  for (genvar k = 0; k < Steps; k++) begin : g_sq
    if (k == 0) begin : g_first
      always_comb sq_d[k] = sq_step(sq_in);
    end else begin : g_next
      always_comb sq_d[k] = sq_step(sq_q[k-1]);
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_q[k] <= sq_d[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q <= '0;
    end else if (en) begin
      sq_v_q <= {sq_v_q[Steps-2:0], valid_i};
    end
  end

  // divider operands: (|n| * 2^f + s) / 2s
  assign root   = sq_q[Steps-1].root;
  assign half_w = ({1'b0, root} + 1'b1);

  always_comb begin
    for (int j = 0; j < rm2q_pkg::Lanes; j++) begin
      mag[j] = sq_q[Steps-1].n[j][rm2q_pkg::NumW-1] ?
               (~sq_q[Steps-1].n[j] + 1'b1) : sq_q[Steps-1].n[j];
      dvd[j] = rm2q_pkg::DvdW'({mag[j], {rm2q_pkg::FracBits{1'b0}}}) +
               rm2q_pkg::DvdW'(root);
      side_in.neg[j] = sq_q[Steps-1].n[j][rm2q_pkg::NumW-1];
    end
    side_in.br    = sq_q[Steps-1].br;
    side_in.degen = sq_q[Steps-1].degen;
    side_in.half  = half_w[rm2q_pkg::SqrtW:1];
  end

  rm2q_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_v_q[Steps-1]),
    .dvd_i   (dvd),
    .dsr_i   ({root, 1'b0}),
    .side_i  (side_in),
    .valid_o (dv_valid),
    .quo_o   (quo),
    .side_o  (side_out)
  );

  // saturate and place parts by branch
  assign p0 = sat_part(quo[0], side_out.neg[0]);
  assign p1 = sat_part(quo[1], side_out.neg[1]);
  assign p2 = sat_part(quo[2], side_out.neg[2]);
  assign ph = sat_part(rm2q_pkg::DvdW'(side_out.half), 1'b0);

  always_comb begin
    case (side_out.br)
      rm2q_pkg::BrTrace: begin
        qa_d = p0; qb_d = p1; qc_d = p2; qw_d = ph;
      end
      rm2q_pkg::BrX: begin
        qa_d = ph; qb_d = p0; qc_d = p1; qw_d = p2;
      end
      rm2q_pkg::BrY: begin
        qa_d = p0; qb_d = ph; qc_d = p1; qw_d = p2;
      end
      default: begin
        qa_d = p0; qb_d = p1; qc_d = ph; qw_d = p2;
      end
    endcase
    if (side_out.degen) begin
      qa_d = '0; qb_d = '0; qc_d = '0; qw_d = '0;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      qa_q <= qa_d;
      qb_q <= qb_d;
      qc_q <= qc_d;
      qw_q <= qw_d;
      br_q <= side_out.br;
      dg_q <= side_out.degen;
    end
  end

  assign quat_o.valid       = out_v_q;
  assign quat_o.qa          = qa_q;
  assign quat_o.qb          = qb_q;
  assign quat_o.qc          = qc_q;
  assign quat_o.qw          = qw_q;
  assign quat_o.branch_used = br_q;
  assign quat_o.degenerate  = dg_q;

endmodule

`default_nettype wire

/* rtl/rotation_matrix_to_quaternion.sv */
// rotation matrix to unit quaternion (Shepperd's method)
//
// mat_i carries one 3x3 matrix of signed Q1.14 elements per transaction;
// quat_o returns qa, qb, qc, qw (scalar last, saturated to +-1.0), the
// branch taken and a degenerate flag (radicand not positive, parts zero).
// both channels are valid/ready; a transaction completes when both are high.
//
// path from accept to valid result, with 14 fraction bits: input register,
// queue, 16 root steps (one bit per stage), 32 divide steps (one quotient
// bit per stage, three lanes side by side), output register.
// throughput: one matrix per cycle while quat_o.ready is held high, set by
// the fully pipelined root and divider.
//
// reset clears all valid bits and the queue; no result is pending after it.
// when quat_o.ready is low with a result waiting, the back pipeline holds,
// the two-entry queue fills, then the input register, and mat_i.ready drops.
`default_nettype none

module rotation_matrix_to_quaternion (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  rm2q_mat_if.sink      mat_i,
  rm2q_quat_if.source   quat_o
);

  rm2q_pkg::cls_t fr_cls, q_cls;
  logic           fr_valid, fr_ready, q_valid, q_ready;

  rm2q_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .mat_i   (mat_i),
    .cls_o   (fr_cls),
    .valid_o (fr_valid),
    .ready_i (fr_ready)
  );

  rm2q_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cls_i   (fr_cls),
    .valid_i (fr_valid),
    .ready_o (fr_ready),
    .cls_o   (q_cls),
    .valid_o (q_valid),
    .ready_i (q_ready)
  );

  rm2q_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cls_i   (q_cls),
    .valid_i (q_valid),
    .ready_o (q_ready),
    .quat_o  (quat_o)
  );

endmodule

`default_nettype wire

/* rtl/rm2q_chk.sv */
`default_nettype none

module rm2q_chk (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               out_valid_i,
  input wire logic                               out_ready_i,
  input wire logic signed [rm2q_pkg::DataW-1:0]  qa_i,
  input wire logic signed [rm2q_pkg::DataW-1:0]  qb_i,
  input wire logic signed [rm2q_pkg::DataW-1:0]  qc_i,
  input wire logic signed [rm2q_pkg::DataW-1:0]  qw_i,
  input wire logic [1:0]                         branch_i,
  input wire logic                               degen_i
);

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // degenerate results carry a zero quaternion
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && degen_i |-> qa_i == 0 && qb_i == 0 && qc_i == 0 && qw_i == 0)
    else $error("degenerate result with nonzero parts");

  // trace branch gives a positive scalar part
  a_scalar_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !degen_i && branch_i == rm2q_pkg::BrTrace |-> qw_i > 0)
    else $error("scalar part not positive on trace branch");

  // parts stay inside the saturation limits
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |->
      qa_i <= rm2q_pkg::SatHi && qa_i >= -rm2q_pkg::SatLo &&
      qb_i <= rm2q_pkg::SatHi && qb_i >= -rm2q_pkg::SatLo &&
      qc_i <= rm2q_pkg::SatHi && qc_i >= -rm2q_pkg::SatLo &&
      qw_i <= rm2q_pkg::SatHi && qw_i >= -rm2q_pkg::SatLo)
    else $error("quaternion part outside saturation range");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !out_valid_i)
    else $error("result valid right after reset");

endmodule

bind rotation_matrix_to_quaternion rm2q_chk u_rm2q_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (quat_o.valid),
  .out_ready_i (quat_o.ready),
  .qa_i        (quat_o.qa),
  .qb_i        (quat_o.qb),
  .qc_i        (quat_o.qc),
  .qw_i        (quat_o.qw),
  .branch_i    (quat_o.branch_used),
  .degen_i     (quat_o.degenerate)
);

`default_nettype wire
